// ===== rtl/ic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ic_pkg
// Shared constants and the word type that travels along the cell chain.
// ----------------------------------------------------------------------------
package ic_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int VALUE_W   = 32;
    localparam int CNT_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int TOTAL_W   = 15;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 16;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic [CNT_W-1:0]          cnt;
        logic                      placed;
    } token_t;

endpackage

// ===== rtl/ic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ic_cell
// One storage cell: holds one element, counts a passing word against it.
// ----------------------------------------------------------------------------
module ic_cell
    import ic_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  token_t tok_in,
    output token_t tok_out
);

    logic signed [VALUE_W-1:0] stored_reg;
    logic signed [VALUE_W-1:0] stored_next;
    logic                      full_reg;
    logic                      full_next;
    token_t                    tok_reg;
    token_t                    tok_next;
    logic                      store;
    logic                      gt;

    always_comb begin
        store       = tok_in.valid && !full_reg && !tok_in.placed;
        gt          = full_reg && (stored_reg > tok_in.value);
        stored_next = store ? tok_in.value : stored_reg;
        full_next   = full_reg;
        tok_next    = tok_in;
        if (tok_in.valid) begin
            full_next       = tok_in.last ? 1'b0 : (full_reg | store);
            tok_next.cnt    = tok_in.cnt + CNT_W'(gt);
            tok_next.placed = tok_in.placed | store;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            tok_reg  <= '0;
        end else if (adv) begin
            full_reg <= full_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stored_reg <= stored_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/ic_tail.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ic_tail
// End of the chain: accumulates counts, tracks overflow, holds the result.
// ----------------------------------------------------------------------------
module ic_tail
    import ic_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  token_t              tok_in,
    input  logic                m_tready,
    output logic                adv,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;
    logic [TOTAL_W:0]    sum;
    logic [TOTAL_W-1:0]  sat;
    logic                ovf_now;

    always_comb begin
        adv     = !(tok_in.valid && tok_in.last && out_valid_reg && !m_tready);
        sum     = {1'b0, total_reg}
                + (tok_in.placed ? (TOTAL_W+1)'(tok_in.cnt) : '0);
        sat     = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        ovf_now = ovf_reg | !tok_in.placed;

        total_next     = total_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (tok_in.valid && adv) begin
            if (tok_in.last) begin
                total_next     = '0;
                ovf_next       = 1'b0;
                out_valid_next = 1'b1;
                out_data_next  = {ovf_now, sat};
            end else begin
                total_next = sat;
                ovf_next   = ovf_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/inversion_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inversion_counter_unit
// Counts inversion pairs in a stream of signed 32-bit sequences.
// ----------------------------------------------------------------------------
// Each word carries one element; tlast ends a sequence, and one result word
// follows for it holding the count of pairs where an earlier element is
// strictly greater than a later one, saturated at 32767, and a flag set when
// the sequence had more than MAX_ITEMS elements (the surplus is ignored).
// Elements travel along a chain of MAX_ITEMS cells, one cell per cycle while
// the chain advances, each cell comparing against the element it holds, so
// a word is accepted every cycle unless the chain is held. Input stalls only
// while a finished result waits at the output and another sequence end has
// reached the end of the chain.
// ----------------------------------------------------------------------------
module inversion_counter_unit
    import ic_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // [31:0] value
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // [14:0] inversions, [15] overflow
);

    token_t tok [0:MAX_ITEMS];
    logic   adv;

    always_comb begin
        tok[0].valid  = s_tvalid;
        tok[0].value  = s_tdata[VALUE_W-1:0];
        tok[0].last   = s_tlast;
        tok[0].cnt    = '0;
        tok[0].placed = 1'b0;
    end

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        ic_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    ic_tail u_tail (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tok_in   (tok[MAX_ITEMS]),
        .m_tready (m_tready),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    assign s_tready = adv;

endmodule

// ===== rtl/ic_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ic_checker
// Port-level checks on the inversion counter, bound to the top level.
// ----------------------------------------------------------------------------
module ic_checker
    import ic_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("Input word changed while stalled.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result word changed while stalled.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result word valid straight after reset.");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("Input stalled without a waiting result word.");

    a_result_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("Result word appeared while the chain was held.");

endmodule

bind inversion_counter_unit ic_checker u_ic_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
